/* rtl/core/rfmb_pkg.sv */
package rfmb_pkg;

  // Frame store geometry.
  localparam int unsigned FB_DEPTH = 4096;
  localparam int unsigned FB_AW    = $clog2(FB_DEPTH);

  // Field widths fixed by the command format.
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned SW_W       = 13;
  localparam int unsigned LO_W       = 12;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // Linear offsets are kept exact; this holds the largest offset that a
  // command can reach before it stops.
  localparam int unsigned OFF_W  = 27;
  localparam int unsigned PROD_W = COORD_W + SW_W;

  // Register reset values.
  localparam logic [SW_W-1:0] SW_RESET = SW_W'(64);
  localparam logic [LO_W-1:0] LO_RESET = LO_W'(4095);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_OFFSET  = 1'b1;

  // Command codes; the fourth code does nothing.
  typedef enum logic [1:0] {
    FUNC_FILL = 2'd0,
    FUNC_MOVE = 2'd1,
    FUNC_READ = 2'd2
  } func_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ROW,
    ST_PIX,
    ST_MV_DST,
    ST_MV_SRC,
    ST_RD_CHK,
    ST_RD_DATA,
    ST_DONE
  } state_e;

  // Request from the sequencer to the frame store.
  typedef struct packed {
    logic               we;
    logic [FB_AW-1:0]   waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [FB_AW-1:0]   raddr;
  } ram_req_t;

endpackage

/* rtl/core/rfmb_frame_ram.sv */
module rfmb_frame_ram (
  input  logic                          clk_i,
  input  rfmb_pkg::ram_req_t            req_i,
  output logic [rfmb_pkg::COLOR_W-1:0]  rdata_o
);
  import rfmb_pkg::*;

  logic [COLOR_W-1:0] mem_q [FB_DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  // One write port and one read port; read data is registered and appears in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rect_fill_move_blitter.sv */
// Rectangle fill, move and pixel read engine over a byte-per-pixel frame
// store of 4096 entries. After reset the block clears the store, one entry
// a cycle, and accepts no command until that is done. One command is
// processed at a time, and each gives one result beat; the next command is
// taken while a result still waits at the output. The frame store has one
// write port and one read port, which sets the pace: a fill writes one
// pixel a cycle, a move steps through a read, a destination write and a
// source write for each pixel, and each rectangle row adds a row set-up
// step. A command also passes a set-up step before its walk and a hand-off
// step at its end, which waits while the previous result is still untaken.
// A read checks the limit and then reads the pixel; an empty rectangle or
// the unused code goes straight to the hand-off. Configuration is taken on
// any cycle with the write enable high and is meant to change only while
// idle.
module rect_fill_move_blitter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [rfmb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rfmb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Command channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       func_i,
  input  logic [rfmb_pkg::COORD_W-1:0]     src_x_i,
  input  logic [rfmb_pkg::COORD_W-1:0]     src_y_i,
  input  logic [rfmb_pkg::SIZE_W-1:0]      rect_width_i,
  input  logic [rfmb_pkg::SIZE_W-1:0]      rect_height_i,
  input  logic [rfmb_pkg::COORD_W-1:0]     dst_x_i,
  input  logic [rfmb_pkg::COORD_W-1:0]     dst_y_i,
  input  logic [rfmb_pkg::COLOR_W-1:0]     color_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rfmb_pkg::COLOR_W-1:0]     pixel_value_o,
  output logic                             any_clipped_o
);
  import rfmb_pkg::*;

  state_e             state_q, state_d;
  logic [SW_W-1:0]    sw_q;
  logic [LO_W-1:0]    lo_q;
  logic [FB_AW-1:0]   clr_q;
  logic               out_valid_q;

  logic [1:0]         func_q;
  logic [COORD_W-1:0] sx_q, sy_q, dx_q, dy_q;
  logic [SIZE_W-1:0]  w_q, h_q, x_q, y_q;
  logic [COLOR_W-1:0] col_q;
  logic [OFF_W-1:0]   s_row_q, d_row_q, s_off_q, d_off_q;
  logic               clip_q;
  logic [COLOR_W-1:0] pix_q;
  logic [COLOR_W-1:0] out_pix_q;
  logic               out_clip_q;

  logic [OFF_W-1:0]   lim;
  logic [PROD_W-1:0]  s_prod, d_prod;
  logic               src_out, dst_out, last_x, last_y, is_move, take_in, send_out;
  logic [OFF_W-1:0]   wr_off;
  ram_req_t           ram_req;
  logic [COLOR_W-1:0] ram_rdata;

  // Highest usable offset: the register, clipped to the store.
  assign lim = (OFF_W'(lo_q) > OFF_W'(FB_DEPTH - 1)) ? OFF_W'(FB_DEPTH - 1) : OFF_W'(lo_q);

  // Row bases of the first source and destination rows.
  assign s_prod = PROD_W'(sy_q) * PROD_W'(sw_q);
  assign d_prod = PROD_W'(dy_q) * PROD_W'(sw_q);

  assign src_out  = s_off_q > lim;
  assign dst_out  = d_off_q > lim;
  assign last_x   = (x_q + SIZE_W'(1)) == w_q;
  assign last_y   = (y_q + SIZE_W'(1)) == h_q;
  assign is_move  = func_q == FUNC_MOVE;
  assign take_in  = in_valid_i && in_ready_o;
  assign send_out = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == FB_AW'(FB_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_READ) begin
            state_d = ST_MUL;
          end else if ((func_i == FUNC_FILL || func_i == FUNC_MOVE) &&
                       rect_width_i != '0 && rect_height_i != '0) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: state_d = ST_ROW;
      ST_ROW: state_d = (func_q == FUNC_READ) ? ST_RD_CHK : ST_PIX;
      ST_PIX: begin
        if (src_out) begin
          // Offsets never fall, so a row start beyond the limit ends it all.
          if (x_q == '0 || last_y) state_d = ST_DONE;
          else                     state_d = ST_ROW;
        end else if (is_move) begin
          state_d = ST_MV_DST;
        end else if (last_x) begin
          state_d = last_y ? ST_DONE : ST_ROW;
        end
      end
      ST_MV_DST: state_d = ST_MV_SRC;
      ST_MV_SRC: begin
        if (last_x) state_d = last_y ? ST_DONE : ST_ROW;
        else        state_d = ST_PIX;
      end
      ST_RD_CHK:  state_d = src_out ? ST_DONE : ST_RD_DATA;
      ST_RD_DATA: state_d = ST_DONE;
      ST_DONE: begin
        if (send_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Frame store requests and handshake outputs.
  always_comb begin
    ram_req       = '0;
    wr_off        = '0;
    in_ready_o    = state_q == ST_IDLE;
    unique case (state_q)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
      end
      ST_PIX: begin
        if (!src_out) begin
          if (is_move) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = s_off_q[FB_AW-1:0];
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = s_off_q[FB_AW-1:0];
            ram_req.wdata = col_q;
            wr_off        = s_off_q;
          end
        end
      end
      ST_MV_DST: begin
        if (!dst_out) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = d_off_q[FB_AW-1:0];
          ram_req.wdata = ram_rdata;
          wr_off        = d_off_q;
        end
      end
      ST_MV_SRC: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = s_off_q[FB_AW-1:0];
        ram_req.wdata = col_q;
        wr_off        = s_off_q;
      end
      ST_RD_CHK: begin
        if (!src_out) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = s_off_q[FB_AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sw_q        <= SW_RESET;
      lo_q        <= LO_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + FB_AW'(1);
      if (state_q == ST_DONE && send_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCREEN_WIDTH: sw_q <= cfg_data_i[SW_W-1:0];
          CFG_LAST_OFFSET:  lo_q <= cfg_data_i[LO_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Command datapath: rectangle walk with running offsets.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (take_in) begin
          func_q <= func_i;
          sx_q   <= src_x_i;
          sy_q   <= src_y_i;
          w_q    <= rect_width_i;
          h_q    <= rect_height_i;
          dx_q   <= dst_x_i;
          dy_q   <= dst_y_i;
          col_q  <= color_i;
          clip_q <= 1'b0;
          pix_q  <= '0;
          y_q    <= '0;
        end
      end
      ST_MUL: begin
        s_row_q <= OFF_W'(s_prod);
        d_row_q <= OFF_W'(d_prod);
      end
      ST_ROW: begin
        s_off_q <= s_row_q + OFF_W'(sx_q);
        d_off_q <= d_row_q + OFF_W'(dx_q);
        x_q     <= '0;
      end
      ST_PIX: begin
        if (src_out) begin
          clip_q  <= 1'b1;
          y_q     <= y_q + SIZE_W'(1);
          s_row_q <= s_row_q + OFF_W'(sw_q);
          d_row_q <= d_row_q + OFF_W'(sw_q);
        end else if (!is_move) begin
          x_q     <= x_q + SIZE_W'(1);
          s_off_q <= s_off_q + OFF_W'(1);
          d_off_q <= d_off_q + OFF_W'(1);
          if (last_x) begin
            y_q     <= y_q + SIZE_W'(1);
            s_row_q <= s_row_q + OFF_W'(sw_q);
            d_row_q <= d_row_q + OFF_W'(sw_q);
          end
        end
      end
      ST_MV_DST: begin
        if (dst_out) clip_q <= 1'b1;
      end
      ST_MV_SRC: begin
        x_q     <= x_q + SIZE_W'(1);
        s_off_q <= s_off_q + OFF_W'(1);
        d_off_q <= d_off_q + OFF_W'(1);
        if (last_x) begin
          y_q     <= y_q + SIZE_W'(1);
          s_row_q <= s_row_q + OFF_W'(sw_q);
          d_row_q <= d_row_q + OFF_W'(sw_q);
        end
      end
      ST_RD_CHK: begin
        if (src_out) clip_q <= 1'b1;
      end
      ST_RD_DATA: pix_q <= ram_rdata;
      ST_DONE: begin
        if (send_out) begin
          out_pix_q  <= pix_q;
          out_clip_q <= clip_q;
        end
      end
      default: begin
      end
    endcase
  end

  rfmb_frame_ram u_frame_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_pix_q;
  assign any_clipped_o = out_clip_q;

  // A command write never lands beyond the usable limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we && state_q != ST_CLEAR) |-> (wr_off <= lim))
    else $error("frame store written beyond the pixel limit");

  // The destination write always uses data read in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MV_DST) |-> ($past(state_q) == ST_PIX && $past(ram_req.re)))
    else $error("move destination step without a source read");

  // Read data is only taken after a read was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_DATA) |-> $past(ram_req.re))
    else $error("pixel read result taken without a read");

  // The column and row counters stay inside the rectangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX || state_q == ST_MV_SRC) |-> (x_q < w_q && y_q < h_q))
    else $error("rectangle walk left the rectangle");

  // No command is taken while the store is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!in_ready_o && !out_valid_o))
    else $error("command handshake during the clearing pass");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import rfmb_pkg::*;

  // The command format leaves the fourth code unused; the block must ignore it.
  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [COLOR_W-1:0] color;
  } blit_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_value;
    logic               any_clipped;
  } blit_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            func_i;
  logic [COORD_W-1:0]    src_x_i;
  logic [COORD_W-1:0]    src_y_i;
  logic [SIZE_W-1:0]     rect_width_i;
  logic [SIZE_W-1:0]     rect_height_i;
  logic [COORD_W-1:0]    dst_x_i;
  logic [COORD_W-1:0]    dst_y_i;
  logic [COLOR_W-1:0]    color_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COLOR_W-1:0]    pixel_value_o;
  logic                  any_clipped_o;

  // Mirror of the frame store and of the two registers.
  logic [COLOR_W-1:0] frame_mirror [FB_DEPTH];
  logic [SW_W-1:0]    cur_screen_width;
  logic [LO_W-1:0]    cur_last_offset;

  blit_result_t pending_results [$];
  blit_result_t want;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_idle_pct  = 0;

  rect_fill_move_blitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .dst_x_i       (dst_x_i),
    .dst_y_i       (dst_y_i),
    .color_i       (color_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .any_clipped_o (any_clipped_o)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Linear offset of a pixel, kept exact so that nothing wraps.
  function automatic longint unsigned pixel_offset(input longint unsigned x,
                                                   input longint unsigned y);
    return y * cur_screen_width + x;
  endfunction

  // Works out the result of one command and applies its writes to the mirror.
  function automatic blit_result_t blit_predict(input blit_cmd_t c);
    blit_result_t      r;
    longint unsigned   lim;
    longint unsigned   so;
    longint unsigned   d;
    longint unsigned   x;
    longint unsigned   y;
    r   = '0;
    lim = (cur_last_offset > FB_DEPTH - 1) ? FB_DEPTH - 1 : cur_last_offset;
    if (c.func == FUNC_FILL || c.func == FUNC_MOVE) begin
      for (y = 0; y < c.rect_height; y++) begin
        // Offsets only grow along a row and down the rows, so stop at the first miss.
        if (pixel_offset(c.src_x, c.src_y + y) > lim) begin
          if (c.rect_width != 0) r.any_clipped = 1'b1;
          break;
        end
        for (x = 0; x < c.rect_width; x++) begin
          so = pixel_offset(c.src_x + x, c.src_y + y);
          if (so > lim) begin
            r.any_clipped = 1'b1;
            break;
          end
          if (c.func == FUNC_FILL) begin
            frame_mirror[so] = c.color;
          end else begin
            d = pixel_offset(c.dst_x + x, c.dst_y + y);
            if (d <= lim) frame_mirror[d] = frame_mirror[so];
            else r.any_clipped = 1'b1;
            frame_mirror[so] = c.color;
          end
        end
      end
    end else if (c.func == FUNC_READ) begin
      so = pixel_offset(c.src_x, c.src_y);
      if (so <= lim) r.pixel_value = frame_mirror[so];
      else r.any_clipped = 1'b1;
    end
    return r;
  endfunction

  // Sends one command beat, with random idle cycles ahead of it, and records
  // its expected result once the beat is taken.
  task automatic send_command(input blit_cmd_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    func_i        = c.func;
    src_x_i       = c.src_x;
    src_y_i       = c.src_y;
    rect_width_i  = c.rect_width;
    rect_height_i = c.rect_height;
    dst_x_i       = c.dst_x;
    dst_y_i       = c.dst_y;
    color_i       = c.color;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(blit_predict(c));
    @(negedge clk_i);
  endtask

  task automatic issue(input logic [1:0] func, input int unsigned sx, input int unsigned sy,
                       input int unsigned w, input int unsigned h, input int unsigned dx,
                       input int unsigned dy, input int unsigned col);
    blit_cmd_t c;
    c.func        = func;
    c.src_x       = COORD_W'(sx);
    c.src_y       = COORD_W'(sy);
    c.rect_width  = SIZE_W'(w);
    c.rect_height = SIZE_W'(h);
    c.dst_x       = COORD_W'(dx);
    c.dst_y       = COORD_W'(dy);
    c.color       = COLOR_W'(col);
    send_command(c);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SCREEN_WIDTH) cur_screen_width = val;
    else cur_last_offset = val[LO_W-1:0];
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned span);
    if ($urandom_range(0, 4) == 0) return COORD_W'($urandom_range(0, 4095));
    return COORD_W'($urandom_range(0, span));
  endfunction

  // Random command aimed mostly at the visible part of the screen.
  function automatic blit_cmd_t random_command();
    blit_cmd_t   c;
    int unsigned pick;
    int unsigned x_span;
    int unsigned y_span;
    int unsigned size_max;
    if (cur_screen_width == 0) begin
      x_span = 80;
      y_span = 6;
    end else begin
      x_span = (cur_screen_width > 78) ? 80 : cur_screen_width + 2;
      y_span = cur_last_offset / cur_screen_width + 2;
      if (y_span > 80) y_span = 80;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) c.func = FUNC_FILL;
    else if (pick < 70) c.func = FUNC_MOVE;
    else if (pick < 95) c.func = FUNC_READ;
    else c.func = FUNC_NONE;
    size_max      = ($urandom_range(0, 4) == 0) ? 24 : 6;
    c.src_x       = pick_coord(x_span);
    c.src_y       = pick_coord(y_span);
    c.dst_x       = pick_coord(x_span);
    c.dst_y       = pick_coord(y_span);
    c.rect_width  = SIZE_W'($urandom_range(0, size_max));
    c.rect_height = SIZE_W'($urandom_range(0, size_max));
    c.color       = COLOR_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("mismatch: %s", what);
  endtask

  // Receiver side: random back-pressure on the result channel.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Each result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result pixel %0d clipped %0b",
                                pixel_value_o, any_clipped_o));
      end else begin
        want = pending_results.pop_front();
        if (pixel_value_o !== want.pixel_value)
          note_mismatch($sformatf("pixel_value expected %0d got %0d",
                                  want.pixel_value, pixel_value_o));
        if (any_clipped_o !== want.any_clipped)
          note_mismatch($sformatf("any_clipped expected %0b got %0b",
                                  want.any_clipped, any_clipped_o));
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL rect_fill_move_blitter");
      $finish;
    end
  end

  // The store comes out of reset cleared; wait for the clearing pass first.
  task automatic test_after_reset();
    while (!in_ready_o) @(negedge clk_i);
    write_register(CFG_SCREEN_WIDTH, 13'd64);
    write_register(CFG_LAST_OFFSET, 13'd4095);
    issue(FUNC_READ, 0, 0, 0, 0, 0, 0, 8'hFF);
    issue(FUNC_READ, 63, 63, 4096, 4096, 4095, 4095, 8'h00);
    wait_drained();
  endtask

  task automatic test_fill();
    // A row of 4096 pixels wraps through the whole store.
    issue(FUNC_FILL, 0, 0, 4096, 1, 0, 0, 8'hFF);
    // A tall column runs off the bottom of the store.
    issue(FUNC_FILL, 0, 0, 1, 4096, 0, 0, 8'h5A);
    issue(FUNC_FILL, 4095, 4095, 4096, 4096, 4095, 4095, 8'h00);
    // Wrapping past the row end.
    issue(FUNC_FILL, 63, 0, 2, 2, 0, 0, 8'hA5);
    // Empty rectangles change nothing.
    issue(FUNC_FILL, 4, 4, 0, 5, 0, 0, 8'h01);
    issue(FUNC_FILL, 4, 4, 5, 0, 0, 0, 8'h02);
    // Origin beyond the store with zero width: not clipped.
    issue(FUNC_FILL, 0, 4095, 0, 3, 0, 0, 8'h03);
    issue(FUNC_FILL, 1, 0, 4095, 1, 0, 0, 8'h7E);
    wait_drained();
  endtask

  task automatic test_move();
    issue(FUNC_MOVE, 0, 0, 4, 3, 10, 10, 8'h11);
    // Overlapping source and destination see earlier writes.
    issue(FUNC_MOVE, 2, 2, 5, 2, 3, 2, 8'h22);
    issue(FUNC_MOVE, 0, 1, 3, 2, 4095, 4095, 8'h33);
    // Source runs past the last pixel.
    issue(FUNC_MOVE, 62, 63, 4, 1, 0, 5, 8'h44);
    issue(FUNC_MOVE, 5, 5, 2, 2, 5, 5, 8'h55);
    wait_drained();
  endtask

  task automatic test_read();
    issue(FUNC_READ, 0, 64, 0, 0, 0, 0, 8'h00);
    issue(FUNC_READ, 4095, 4095, 0, 0, 0, 0, 8'h00);
    issue(FUNC_NONE, 4095, 4095, 8191, 8191, 4095, 4095, 8'hFF);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // Zero width: every row shares the same offsets; only offset zero is valid.
    write_register(CFG_SCREEN_WIDTH, 13'd0);
    write_register(CFG_LAST_OFFSET, 13'd0);
    issue(FUNC_FILL, 0, 3, 2, 3, 0, 0, 8'hC3);
    issue(FUNC_READ, 0, 5, 0, 0, 0, 0, 8'h00);
    wait_drained();
    // Row as wide as the store; the top bit of the write data is dropped for the limit.
    write_register(CFG_SCREEN_WIDTH, 13'd4096);
    write_register(CFG_LAST_OFFSET, 13'h1FFF);
    issue(FUNC_FILL, 4090, 0, 10, 2, 0, 0, 8'h3C);
    wait_drained();
    write_register(CFG_SCREEN_WIDTH, 13'h1FFF);
    write_register(CFG_LAST_OFFSET, 13'd2047);
    issue(FUNC_MOVE, 0, 0, 3, 2, 5, 0, 8'h99);
    wait_drained();
    write_register(CFG_SCREEN_WIDTH, 13'd1);
    write_register(CFG_LAST_OFFSET, 13'd4095);
    issue(FUNC_READ, 10, 20, 0, 0, 0, 0, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned width,
                                     input int unsigned limit, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_register(CFG_SCREEN_WIDTH, CFG_DATA_W'(width));
    write_register(CFG_LAST_OFFSET, CFG_DATA_W'(limit));
    repeat (count) send_command(random_command());
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SCREEN_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_FILL;
    src_x_i       = '0;
    src_y_i       = '0;
    rect_width_i  = '0;
    rect_height_i = '0;
    dst_x_i       = '0;
    dst_y_i       = '0;
    color_i       = '0;
    foreach (frame_mirror[i]) frame_mirror[i] = '0;
    cur_screen_width = SW_RESET;
    cur_last_offset  = LO_RESET;
    send_idle_pct    = 23;
    recv_idle_pct    = 50;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_fill();
    test_move();
    test_read();
    test_register_extremes();
    test_random_traffic(40, 64, 4095, 23, 50);
    test_random_traffic(40, 13, 1000, 50, 23);
    test_random_traffic(38, 0, 300, 0, 0);

    // Let any stray beat show up before the verdict.
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS rect_fill_move_blitter");
    end else begin
      $display("FAIL rect_fill_move_blitter");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rfmb_pkg.sv
rtl/core/rfmb_frame_ram.sv
rtl/core/rect_fill_move_blitter.sv
dv/testbench.sv
